>>> rtl/khwm_pkg.sv
// Shared types, codes and defaults for the keyed high-water-mark table.
`default_nettype none

package khwm_pkg;

    // Default table depth
    localparam int ENTRIES_DEF = 32;

    // Operation codes
    typedef enum logic [1:0] {
        OP_QUERY = 2'd0,
        OP_RAISE = 2'd1,
        OP_WIPE  = 2'd2
    } t_op;

    // One input item
    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] fingerprint;
        logic        testnet;
        logic [3:0]  script_type;
        logic [31:0] mark_index;
    } t_in_item;

    // One result item
    typedef struct packed {
        logic        found;
        logic [31:0] high_mark;
        logic        dropped;
    } t_out_item;

    // Lookup key as stored in the table
    typedef struct packed {
        logic [3:0]  script_type;
        logic        testnet;
        logic [31:0] fingerprint;
    } t_key;

    // One table entry
    typedef struct packed {
        t_key        key;
        logic [31:0] mark;
    } t_entry;

    // Build the lookup key of an item
    function automatic t_key make_key(input t_in_item item);
        t_key k;
        k.script_type = item.script_type;
        k.testnet     = item.testnet;
        k.fingerprint = item.fingerprint;
        return k;
    endfunction

endpackage

`default_nettype wire

>>> rtl/keyed_high_water_mark_table_top.sv
// Top level of the keyed high-water-mark table: sequencer plus entry store.
// Wipe and unused codes give their result in the cycle after acceptance; query and
// raise scan the stored entries in order (at most ENTRIES) until a hit or the last one,
// with one read of the entry store per cycle. busy stays high meanwhile.
// Results appear on o_result for one cycle with o_done; the receiver cannot stall.
// Synchronous active-low reset empties the table; entry contents stay undefined.
`default_nettype none

module keyed_high_water_mark_table_top #(
    parameter int ENTRIES = khwm_pkg::ENTRIES_DEF
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_start,
    input  khwm_pkg::t_in_item     i_item,
    output logic                   o_busy,
    output logic                   o_done,
    output khwm_pkg::t_out_item    o_result
);

    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic                 w_we;
    logic [IW-1:0]        w_waddr;
    khwm_pkg::t_entry     w_wdata;
    logic                 w_re;
    logic [IW-1:0]        w_raddr;
    khwm_pkg::t_entry     w_rdata;

    khwm_ctrl #(
        .ENTRIES(ENTRIES)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_item      (i_item),
        .o_busy      (o_busy),
        .o_done      (o_done),
        .o_result    (o_result),
        .o_mem_we    (w_we),
        .o_mem_waddr (w_waddr),
        .o_mem_wdata (w_wdata),
        .o_mem_re    (w_re),
        .o_mem_raddr (w_raddr),
        .i_mem_rdata (w_rdata)
    );

    khwm_mem #(
        .ENTRIES(ENTRIES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // An accepted item either completes at once or keeps the block busy
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy || o_done))
        else $error("accepted item neither in progress nor completed");

    // A dropped raise never reports a hit or a mark
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.dropped) |-> (!o_result.found && o_result.high_mark == 32'd0))
        else $error("dropped result carries found or mark");

    // A result only follows an accepted item or a scan in progress
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(o_busy) || $past(i_start)))
        else $error("result without an item");

endmodule

`default_nettype wire

>>> rtl/khwm_mem.sv
// Entry store: key and mark memory with one write port and a registered read port.
`default_nettype none

module khwm_mem #(
    parameter int ENTRIES = khwm_pkg::ENTRIES_DEF,
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire                    i_clk,
    input  wire                    i_we,
    input  wire [IW-1:0]           i_waddr,
    input  khwm_pkg::t_entry       i_wdata,
    input  wire                    i_re,
    input  wire [IW-1:0]           i_raddr,
    output khwm_pkg::t_entry       o_rdata
);

    khwm_pkg::t_entry r_mem [ENTRIES];
    khwm_pkg::t_entry r_rdata;

    // Write the entry
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

>>> rtl/khwm_ctrl.sv
// Sequencer: scans the entry store, raises or appends marks, and issues results.
`default_nettype none

module khwm_ctrl #(
    parameter int ENTRIES = khwm_pkg::ENTRIES_DEF,
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int CW = $clog2(ENTRIES + 1)
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_start,
    input  khwm_pkg::t_in_item     i_item,
    output logic                   o_busy,
    output logic                   o_done,
    output khwm_pkg::t_out_item    o_result,
    output logic                   o_mem_we,
    output logic [IW-1:0]          o_mem_waddr,
    output khwm_pkg::t_entry       o_mem_wdata,
    output logic                   o_mem_re,
    output logic [IW-1:0]          o_mem_raddr,
    input  khwm_pkg::t_entry       i_mem_rdata
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_SCAN = 2'b10
    } t_state;

    t_state               r_state, n_state;
    khwm_pkg::t_in_item   r_item, n_item;
    logic [CW-1:0]        r_idx, n_idx;
    logic                 r_pend, n_pend;
    logic [CW-1:0]        r_pend_idx, n_pend_idx;
    logic [CW-1:0]        r_count, n_count;
    logic                 r_done, n_done;
    khwm_pkg::t_out_item  r_result, n_result;

    khwm_pkg::t_key       w_key;
    logic                 w_hit;
    logic                 w_last;
    logic                 w_raise;
    logic [31:0]          w_new_mark;

    assign w_key   = khwm_pkg::make_key(r_item);
    assign w_raise = (r_item.operation == khwm_pkg::OP_RAISE);
    assign w_hit   = r_pend && (i_mem_rdata.key == w_key);
    assign w_last  = r_pend ? (CW'(r_pend_idx + CW'(1)) == r_count) : (r_idx >= r_count);
    assign w_new_mark = (r_item.mark_index > i_mem_rdata.mark) ? r_item.mark_index
                                                                : i_mem_rdata.mark;

    // Next-state and store access
    always_comb begin
        n_state     = r_state;
        n_item      = r_item;
        n_idx       = r_idx;
        n_pend      = 1'b0;
        n_pend_idx  = r_pend_idx;
        n_count     = r_count;
        n_done      = 1'b0;
        n_result    = r_result;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_pend_idx[IW-1:0];
        o_mem_wdata = '{key: w_key, mark: r_item.mark_index};
        o_mem_re    = 1'b0;
        o_mem_raddr = r_idx[IW-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_item = i_item;
                    n_idx  = '0;
                    unique case (khwm_pkg::t_op'(i_item.operation))
                        khwm_pkg::OP_QUERY,
                        khwm_pkg::OP_RAISE: begin
                            n_state = S_SCAN;
                        end
                        khwm_pkg::OP_WIPE: begin
                            n_count  = '0;
                            n_done   = 1'b1;
                            n_result = '0;
                        end
                        default: begin
                            n_done   = 1'b1;
                            n_result = '0;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                priority if (w_hit) begin
                    // Key present: report it, raise the mark on a raise request
                    n_result.found     = 1'b1;
                    n_result.dropped   = 1'b0;
                    n_result.high_mark = i_mem_rdata.mark;
                    if (w_raise) begin
                        o_mem_we           = 1'b1;
                        o_mem_wdata.mark   = w_new_mark;
                        n_result.high_mark = w_new_mark;
                    end
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else if (w_last) begin
                    // Key absent: append on a raise if there is room, else drop
                    n_result = '0;
                    if (w_raise) begin
                        if (r_count < CW'(ENTRIES)) begin
                            o_mem_we           = 1'b1;
                            o_mem_waddr        = r_count[IW-1:0];
                            n_count            = CW'(r_count + CW'(1));
                            n_result.high_mark = r_item.mark_index;
                        end else begin
                            n_result.dropped = 1'b1;
                        end
                    end
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    // Advance the scan: issue the next read
                    if (r_idx < r_count) begin
                        o_mem_re   = 1'b1;
                        n_pend     = 1'b1;
                        n_pend_idx = r_idx;
                        n_idx      = CW'(r_idx + CW'(1));
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= 1'b0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_count <= n_count;
            r_done  <= n_done;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_idx      <= n_idx;
        r_pend_idx <= n_pend_idx;
        r_result   <= n_result;
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the keyed high-water-mark table: directed and random items.
`timescale 1ns / 100ps

module tb_top;

    localparam int          ENTRIES     = khwm_pkg::ENTRIES_DEF;
    localparam logic [1:0]  OP_UNUSED   = 2'd3;
    localparam int          KEY_POOL    = 44;
    localparam int          ITEMS_PHASE = 184;
    localparam int          DRAIN_WAIT  = ENTRIES + 8;
    localparam int          CYCLE_LIMIT = 400000;

    // Mirror of the table: predicts the result of every accepted item
    class hwm_ledger;
        khwm_pkg::t_key      slot_key[ENTRIES];
        logic [31:0]         slot_mark[ENTRIES];
        int unsigned         slot_count;
        khwm_pkg::t_out_item pending_marks[$];
        int                  n_errors;

        function new();
            slot_count = 0;
            n_errors   = 0;
        endfunction

        // Apply an accepted item to the mirror and queue its expected result
        function void note_item(khwm_pkg::t_in_item item);
            khwm_pkg::t_key      k;
            khwm_pkg::t_out_item want;
            int                  hit;
            k.script_type = item.script_type;
            k.testnet     = item.testnet;
            k.fingerprint = item.fingerprint;
            want = '0;
            hit  = -1;
            if (item.operation == khwm_pkg::OP_QUERY || item.operation == khwm_pkg::OP_RAISE) begin
                for (int i = 0; i < slot_count; i++) begin
                    if (hit < 0 && slot_key[i] == k)
                        hit = i;
                end
                if (hit >= 0) begin
                    want.found = 1'b1;
                    if (item.operation == khwm_pkg::OP_RAISE &&
                        item.mark_index > slot_mark[hit])
                        slot_mark[hit] = item.mark_index;
                    want.high_mark = slot_mark[hit];
                end else if (item.operation == khwm_pkg::OP_RAISE) begin
                    if (slot_count < ENTRIES) begin
                        slot_key[slot_count]  = k;
                        slot_mark[slot_count] = item.mark_index;
                        slot_count++;
                        want.high_mark = item.mark_index;
                    end else begin
                        want.dropped = 1'b1;
                    end
                end
            end else if (item.operation == khwm_pkg::OP_WIPE) begin
                slot_count = 0;
            end
            pending_marks.push_back(want);
        endfunction

        // Compare a result with the oldest expectation
        function void check_result(khwm_pkg::t_out_item got);
            khwm_pkg::t_out_item want;
            if (pending_marks.size() == 0) begin
                $error("result with no item outstanding: found=%0d high_mark=%h dropped=%0d",
                       got.found, got.high_mark, got.dropped);
                n_errors++;
                return;
            end
            want = pending_marks.pop_front();
            if (got.found !== want.found) begin
                $error("found: expected %0d, actual %0d", want.found, got.found);
                n_errors++;
            end
            if (got.high_mark !== want.high_mark) begin
                $error("high_mark: expected %h, actual %h", want.high_mark, got.high_mark);
                n_errors++;
            end
            if (got.dropped !== want.dropped) begin
                $error("dropped: expected %0d, actual %0d", want.dropped, got.dropped);
                n_errors++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_start;
    khwm_pkg::t_in_item  i_item;
    logic                o_busy;
    logic                o_done;
    khwm_pkg::t_out_item o_result;

    hwm_ledger      ledger;
    khwm_pkg::t_key key_pool[KEY_POOL];
    int             cycle_count;

    keyed_high_water_mark_table_top u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_done   (o_done),
        .o_result (o_result)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Abort a hung run
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Check results before noting a new item accepted on the same edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done)
                ledger.check_result(o_result);
            if (i_start && !o_busy)
                ledger.note_item(i_item);
        end
    end

    function automatic khwm_pkg::t_in_item build_item(logic [1:0] op, logic [31:0] fp,
                                                      logic tn, logic [3:0] st,
                                                      logic [31:0] mark);
        khwm_pkg::t_in_item item;
        item.operation   = op;
        item.fingerprint = fp;
        item.testnet     = tn;
        item.script_type = st;
        item.mark_index  = mark;
        return item;
    endfunction

    // Mostly raises and queries on a pool of keys a bit larger than the table
    function automatic khwm_pkg::t_in_item random_item();
        khwm_pkg::t_in_item item;
        int                 pick;
        pick = $urandom_range(999);
        if (pick < 6)
            item.operation = khwm_pkg::OP_WIPE;
        else if (pick < 12)
            item.operation = OP_UNUSED;
        else if (pick < 600)
            item.operation = khwm_pkg::OP_RAISE;
        else
            item.operation = khwm_pkg::OP_QUERY;
        if ($urandom_range(9) == 0) begin
            item.fingerprint = $urandom;
            item.testnet     = 1'($urandom_range(1));
            item.script_type = 4'($urandom_range(15));
        end else begin
            pick = $urandom_range(KEY_POOL - 1);
            item.fingerprint = key_pool[pick].fingerprint;
            item.testnet     = key_pool[pick].testnet;
            item.script_type = key_pool[pick].script_type;
        end
        case ($urandom_range(3))
            0:       item.mark_index = $urandom_range(255);
            1:       item.mark_index = 32'hFFFF_FF00 + $urandom_range(255);
            default: item.mark_index = $urandom;
        endcase
        return item;
    endfunction

    // Offer one item after a random gap and hold it until accepted
    task automatic send_item(input khwm_pkg::t_in_item item, input int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(negedge i_clk);
        end
        i_start <= 1'b1;
        i_item  <= item;
        do @(posedge i_clk); while (o_busy);
        @(negedge i_clk);
    endtask

    initial begin
        int idle_pct;
        ledger  = new();
        i_rst_n = 1'b0;
        i_start = 1'b0;
        i_item  = '0;

        // Keys in groups that share a fingerprint, with random network and script
        for (int i = 0; i < KEY_POOL; i++) begin
            key_pool[i].fingerprint = (i % 4 == 0) ? $urandom : key_pool[i - 1].fingerprint;
            key_pool[i].testnet     = 1'($urandom_range(1));
            key_pool[i].script_type = 4'($urandom_range(15));
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: extremes, monotonic raise, near-miss keys, unused code, wipe
        send_item(build_item(khwm_pkg::OP_QUERY, 32'h0,         1'b0, 4'h0, 32'h0),         22);
        send_item(build_item(khwm_pkg::OP_RAISE, 32'h0,         1'b0, 4'h0, 32'h0),         22);
        send_item(build_item(khwm_pkg::OP_RAISE, 32'h0,         1'b0, 4'h0, 32'hFFFF_FFFF), 22);
        send_item(build_item(khwm_pkg::OP_RAISE, 32'h0,         1'b0, 4'h0, 32'h5),         22);
        send_item(build_item(khwm_pkg::OP_QUERY, 32'h0,         1'b0, 4'h0, 32'hFFFF_FFFF), 22);
        send_item(build_item(khwm_pkg::OP_RAISE, 32'hFFFF_FFFF, 1'b1, 4'hF, 32'h1234_5678), 22);
        send_item(build_item(khwm_pkg::OP_RAISE, 32'hFFFF_FFFF, 1'b1, 4'hF, 32'h1234_5678), 22);
        send_item(build_item(khwm_pkg::OP_QUERY, 32'h0,         1'b1, 4'h0, 32'h0),         22);
        send_item(build_item(khwm_pkg::OP_QUERY, 32'h0,         1'b0, 4'h1, 32'h0),         22);
        send_item(build_item(khwm_pkg::OP_QUERY, 32'h1,         1'b0, 4'h0, 32'h0),         22);
        send_item(build_item(khwm_pkg::OP_QUERY, 32'hFFFF_FFFF, 1'b1, 4'hF, 32'h0),         22);
        send_item(build_item(OP_UNUSED,          32'h0,         1'b0, 4'h0, 32'hFFFF_FFFF), 22);
        send_item(build_item(khwm_pkg::OP_QUERY, 32'h0,         1'b0, 4'h0, 32'h0),         22);
        send_item(build_item(khwm_pkg::OP_WIPE,  32'hFFFF_FFFF, 1'b1, 4'hF, 32'hFFFF_FFFF), 22);
        send_item(build_item(khwm_pkg::OP_QUERY, 32'h0,         1'b0, 4'h0, 32'h0),         22);
        send_item(build_item(khwm_pkg::OP_QUERY, 32'hFFFF_FFFF, 1'b1, 4'hF, 32'h0),         22);

        // Random: light idling, heavy idling, then back to back
        for (int phase = 0; phase < 3; phase++) begin
            idle_pct = (phase == 0) ? 22 : (phase == 1) ? 79 : 0;
            for (int n = 0; n < ITEMS_PHASE; n++)
                send_item(random_item(), idle_pct);
        end
        i_start <= 1'b0;

        // Drain outstanding results, then allow for a stray one
        while (ledger.pending_marks.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (ledger.pending_marks.size() != 0) begin
            $error("%0d results never arrived", ledger.pending_marks.size());
            ledger.n_errors++;
        end

        if (ledger.n_errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
